FILE: hw/rtl/buddy_page_allocator_top_assert.svh
// Assertion macros shared by the buddy page allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define BPA_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("buddy allocator check failed");

// Condition holds in the cycle after the trigger.
`define BPA_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("buddy allocator check failed");

`endif

FILE: hw/rtl/bpa_pkg.sv
// Package with constants, types and helper functions of the buddy page allocator.
package bpa_pkg;

    localparam int TOP_ORDER = 10;
    localparam int POOL      = 1 << TOP_ORDER;
    localparam int IDX_W     = TOP_ORDER;
    localparam int CNT_W     = 11;
    localparam int ORD_W     = 4;
    localparam int ACC_W     = CNT_W + TOP_ORDER + 2;
    localparam int NORD      = TOP_ORDER + 1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOOBIG  = 2'd1;
    localparam logic [1:0] ST_NOFREE  = 2'd2;
    localparam logic [1:0] ST_DOUBLE  = 2'd3;

    localparam logic [0:0] REG_MAPPED = 1'b0;
    localparam logic [0:0] REG_LIMIT  = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_TAKE, S_SPLIT, S_FCHK,
        S_MREQ, S_MCHK, S_MEND, S_SUM, S_DONE
    } state_t;

    typedef struct packed {
        logic             free;
        logic [ORD_W-1:0] order;
    } ent_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        ent_t             data;
    } mem_wr_t;

    // Order of the power of two that covers n; zero counts as one.
    function automatic logic [ORD_W-1:0] ceil_order(input logic [CNT_W-1:0] n);
        logic [ORD_W-1:0] o;
        o = '0;
        for (int i = 0; i <= CNT_W; i++) begin
            if ((CNT_W+2)'(1) << i < (CNT_W+2)'(n)) o = ORD_W'(i + 1);
        end
        return o;
    endfunction

    // Order of the largest power of two not above n, capped at the pool size.
    function automatic logic [ORD_W-1:0] floor_order(input logic [CNT_W-1:0] n);
        logic [ORD_W-1:0] o;
        o = '0;
        for (int i = 0; i <= TOP_ORDER; i++) begin
            if ((CNT_W+2)'(1) << i <= (CNT_W+2)'(n)) o = ORD_W'(i);
        end
        return o;
    endfunction

endpackage

FILE: hw/rtl/bpa_ram.sv
// Simple dual-port block table with a registered read port.
module bpa_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 5
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data <= mem[rd_addr];
    end
endmodule

FILE: hw/rtl/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: control sequencer, counters and block table.
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | s_mode, s_page_count, s_page_index
//  m_      | out       | m_valid / m_ready | m_status, m_block_index, m_block_order, m_free_total
//  cfg_    | in        | cfg_we            | cfg_index, cfg_data
// Allocate: scan the table, take the best block, split it down, sum the counters and output (no split if none fits).
// Free: a check, a buddy read and compare per merge level, the end of merging, a write-back, the sum and the output.
// A double free goes from the check, and a request that is too large from idle, straight to the sum and output.
// Reset and each register write run a clearing pass over the table; no transaction is taken.
// A finished result waits in the output register while the next transaction runs; a second
// finished result holds the sequencer and the input until the first one is taken.
module buddy_page_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [10:0] s_page_count,
    input  logic [9:0]  s_page_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [9:0]  m_block_index,
    output logic [3:0]  m_block_order,
    output logic [10:0] m_free_total,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import bpa_pkg::*;
    `include "buddy_page_allocator_top_assert.svh"

    state_t state_reg, state_next;
    logic [CNT_W-1:0] mapped_reg, limit_reg;
    logic [ORD_W-1:0] ord_reg, ord_next, o_reg, o_next, cur_reg, cur_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic             best_v_reg, best_v_next;
    logic [ORD_W-1:0] best_ord_reg, best_ord_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [IDX_W:0]   scan_cnt_reg, scan_cnt_next, clr_cnt_reg;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic [1:0]       status_reg, status_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [ORD_W-1:0] res_ord_reg, res_ord_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ORD_W-1:0] sum_idx_reg, sum_idx_next;
    logic [CNT_W-1:0] cnt_reg [NORD];
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [9:0]       m_block_index_reg;
    logic [3:0]       m_block_order_reg;
    logic [10:0]      m_free_total_reg;

    mem_wr_t          wr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    ent_t             rd_data;
    logic             cnt_en, cnt_up;
    logic [ORD_W-1:0] cnt_ord;
    logic             accept, cfg_hit, out_load;
    logic [IDX_W-1:0] bud;
    logic [ORD_W-1:0] init_ord;
    logic [ORD_W-1:0] cur_dec;

    assign accept   = s_valid && s_ready;
    assign cfg_hit  = cfg_we;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign bud      = base_reg ^ (IDX_W'(1) << o_reg);
    assign init_ord = floor_order(mapped_reg);
    assign cur_dec  = cur_reg - ORD_W'(1);

    bpa_ram #(.DEPTH(POOL), .DATA_W($bits(ent_t))) u_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_cnt_reg == (IDX_W+1)'(POOL - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (ceil_order(s_page_count) > ORD_W'(TOP_ORDER)) state_next = S_SUM;
                    else if (s_mode == MODE_ALLOC) state_next = S_SCAN;
                    else state_next = S_FCHK;
                end
            end
            S_SCAN: if (scan_cnt_reg == (IDX_W+1)'(POOL) && !rd_pend_reg) state_next = S_TAKE;
            S_TAKE:  state_next = best_v_reg ? S_SPLIT : S_SUM;
            S_SPLIT: if (cur_reg <= ord_reg) state_next = S_SUM;
            S_FCHK:  state_next = rd_data.free ? S_SUM : S_MREQ;
            S_MREQ: begin
                if (o_reg >= ORD_W'(TOP_ORDER) || {1'b0, bud} >= limit_reg) state_next = S_MEND;
                else state_next = S_MCHK;
            end
            S_MCHK:  state_next = (rd_data.free && rd_data.order == o_reg) ? S_MREQ : S_MEND;
            S_MEND:  state_next = S_SUM;
            S_SUM:   if (sum_idx_reg == ORD_W'(TOP_ORDER)) state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
        if (cfg_hit) state_next = S_CLEAR;
    end

    // Datapath and memory control.
    always_comb begin
        ord_next      = ord_reg;
        o_next        = o_reg;
        cur_next      = cur_reg;
        base_next     = base_reg;
        best_v_next   = best_v_reg;
        best_ord_next = best_ord_reg;
        best_idx_next = best_idx_reg;
        scan_cnt_next = scan_cnt_reg;
        status_next   = status_reg;
        res_idx_next  = res_idx_reg;
        res_ord_next  = res_ord_reg;
        acc_next      = acc_reg;
        sum_idx_next  = sum_idx_reg;
        wr            = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        cnt_en        = 1'b0;
        cnt_up        = 1'b0;
        cnt_ord       = '0;
        case (state_reg)
            S_CLEAR: begin
                wr.en   = 1'b1;
                wr.addr = clr_cnt_reg[IDX_W-1:0];
                if (clr_cnt_reg == '0) begin
                    wr.data.free  = (mapped_reg != '0);
                    wr.data.order = init_ord;
                end
            end
            S_IDLE: begin
                acc_next      = '0;
                sum_idx_next  = '0;
                best_v_next   = 1'b0;
                scan_cnt_next = '0;
                ord_next      = ceil_order(s_page_count);
                base_next     = s_page_index[IDX_W-1:0];
                o_next        = ceil_order(s_page_count);
                status_next   = ST_TOOBIG;
                res_idx_next  = '0;
                res_ord_next  = '0;
                rd_en         = accept;
                rd_addr       = s_page_index[IDX_W-1:0];
            end
            S_SCAN: begin
                if (scan_cnt_reg != (IDX_W+1)'(POOL)) begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                // Strict compare on order keeps the lowest index among equal orders.
                if (rd_pend_reg && rd_data.free && rd_data.order >= ord_reg &&
                    (!best_v_reg || rd_data.order < best_ord_reg)) begin
                    best_v_next   = 1'b1;
                    best_ord_next = rd_data.order;
                    best_idx_next = rd_addr_reg;
                end
            end
            S_TAKE: begin
                if (best_v_reg) begin
                    wr.en         = 1'b1;
                    wr.addr       = best_idx_reg;
                    wr.data.order = best_ord_reg;
                    cnt_en        = 1'b1;
                    cnt_ord       = best_ord_reg;
                    cur_next      = best_ord_reg;
                    status_next   = ST_OK;
                    res_idx_next  = best_idx_reg;
                    res_ord_next  = ord_reg;
                end else begin
                    status_next = ST_NOFREE;
                end
            end
            S_SPLIT: begin
                if (cur_reg > ord_reg) begin
                    wr.en         = 1'b1;
                    wr.addr       = best_idx_reg + (IDX_W'(1) << cur_dec);
                    wr.data.free  = 1'b1;
                    wr.data.order = cur_dec;
                    cnt_en        = 1'b1;
                    cnt_up        = 1'b1;
                    cnt_ord       = cur_dec;
                    cur_next      = cur_dec;
                end
            end
            S_FCHK: status_next = rd_data.free ? ST_DOUBLE : ST_OK;
            S_MREQ: begin
                rd_en   = 1'b1;
                rd_addr = bud;
            end
            S_MCHK: begin
                if (rd_data.free && rd_data.order == o_reg) begin
                    wr.en         = 1'b1;
                    wr.addr       = bud;
                    wr.data.order = o_reg;
                    cnt_en        = 1'b1;
                    cnt_ord       = o_reg;
                    if (bud < base_reg) base_next = bud;
                    o_next = o_reg + 1'b1;
                end
            end
            S_MEND: begin
                wr.en         = 1'b1;
                wr.addr       = base_reg;
                wr.data.free  = 1'b1;
                wr.data.order = o_reg;
                cnt_en        = 1'b1;
                cnt_up        = 1'b1;
                cnt_ord       = o_reg;
                res_idx_next  = base_reg;
                res_ord_next  = o_reg;
            end
            S_SUM: begin
                acc_next     = acc_reg + (ACC_W'(cnt_reg[sum_idx_reg]) << sum_idx_reg);
                sum_idx_next = sum_idx_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            mapped_reg  <= CNT_W'(POOL);
            limit_reg   <= CNT_W'(POOL);
            clr_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == S_SCAN) && rd_en;
            if (cfg_hit) begin
                if (cfg_index == REG_MAPPED) mapped_reg <= cfg_data;
                else limit_reg <= cfg_data;
                clr_cnt_reg <= '0;
            end else if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        ord_reg      <= ord_next;
        o_reg        <= o_next;
        cur_reg      <= cur_next;
        base_reg     <= base_next;
        best_v_reg   <= best_v_next;
        best_ord_reg <= best_ord_next;
        best_idx_reg <= best_idx_next;
        scan_cnt_reg <= scan_cnt_next;
        status_reg   <= status_next;
        res_idx_reg  <= res_idx_next;
        res_ord_reg  <= res_ord_next;
        acc_reg      <= acc_next;
        sum_idx_reg  <= sum_idx_next;
        rd_addr_reg  <= rd_addr;
        if (out_load) begin
            m_status_reg      <= status_reg;
            m_block_index_reg <= res_idx_reg;
            m_block_order_reg <= res_ord_reg;
            m_free_total_reg  <= (acc_reg > ACC_W'(2047)) ? 11'd2047 : acc_reg[10:0];
        end
    end

    // Per-order free block counters; rebuilt at the start of every clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NORD; i++) cnt_reg[i] <= '0;
        end else if (state_reg == S_CLEAR && clr_cnt_reg == '0) begin
            for (int i = 0; i < NORD; i++) begin
                cnt_reg[i] <= (ORD_W'(i) == init_ord && mapped_reg != '0) ? CNT_W'(1) : '0;
            end
        end else if (cnt_en) begin
            cnt_reg[cnt_ord] <= cnt_up ? cnt_reg[cnt_ord] + 1'b1 : cnt_reg[cnt_ord] - 1'b1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_block_index = m_block_index_reg;
    assign m_block_order = m_block_order_reg;
    assign m_free_total  = m_free_total_reg;

    `BPA_ASSERT_NOW(a_err_zero, m_valid && m_status != ST_OK, m_block_index == '0 && m_block_order == '0)
    `BPA_ASSERT_NOW(a_ord_range, m_valid, m_block_order <= 4'(TOP_ORDER))
    `BPA_ASSERT_NEXT(a_busy_after_accept, accept && !cfg_we, !s_ready)
    `BPA_ASSERT_NOW(a_no_write_split_idle, state_reg == S_IDLE, !wr.en && !cnt_en)
endmodule
